/* hdl/aht_pkg.sv */
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - shared definitions
// Register codes, reset values, fixed field widths and the token type that
// travels from the edge splitter to the threshold engine.
// ----------------------------------------------------------------------------
package aht_pkg;

  localparam int TIME_BITS_DEF = 32;
  localparam int DAC_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CNT_BITS      = 17;
  localparam int PERIOD_BITS   = 16;
  localparam int SAT_BITS      = 32;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  localparam int CENTER_RESET   = 127;
  localparam int HYST_MIN_RESET = 1;
  localparam int HYST_MAX_RESET = 15;
  localparam int PERIOD_RESET   = 116;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_DAC = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYST_MIN   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HYST_MAX   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_SAT_TICKS  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADAPT_EN   = 3'd5;

  // One comparator edge waiting for the engine
  typedef struct packed {
    logic rising;
    logic last;
  } tok_ctl_t;

endpackage

/* hdl/aht_if.sv */
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - channel interfaces
// Valid/ready channels for comparator events and for threshold results.
// ----------------------------------------------------------------------------
interface aht_in_if #(
  parameter int TIME_BITS = aht_pkg::TIME_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 edge_rising;
  logic                 edge_falling;
  logic [TIME_BITS-1:0] timestamp;

  modport source (output valid, edge_rising, edge_falling, timestamp, input ready);
  modport sink   (input valid, edge_rising, edge_falling, timestamp, output ready);
endinterface

interface aht_out_if #(
  parameter int DAC_BITS = aht_pkg::DAC_BITS_DEF
) ();
  logic                valid;
  logic                ready;
  logic [DAC_BITS-1:0] dac_threshold;
  logic                was_rising;
  logic                last;

  modport source (output valid, dac_threshold, was_rising, last, input ready);
  modport sink   (input valid, dac_threshold, was_rising, last, output ready);
endinterface

/* hdl/aht_front.sv */
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - edge splitter
// Accepts one comparator event and pushes one token per flagged edge into the
// queue, rising edge first.
// ----------------------------------------------------------------------------
module aht_front #(
  parameter int TIME_BITS = aht_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  aht_in_if.sink               in_ch,
  input  logic                 q_full,
  output logic                 push,
  output aht_pkg::tok_ctl_t    push_ctl,
  output logic [TIME_BITS-1:0] push_ts
);

  logic                 rise_pend_r;
  logic                 fall_pend_r;
  logic [TIME_BITS-1:0] ts_r;

  assign in_ch.ready     = !rise_pend_r && !fall_pend_r;
  assign push            = (rise_pend_r || fall_pend_r) && !q_full;
  assign push_ctl.rising = rise_pend_r;
  assign push_ctl.last   = !(rise_pend_r && fall_pend_r);
  assign push_ts         = ts_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_pend_r <= 1'b0;
      fall_pend_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      rise_pend_r <= in_ch.edge_rising;
      fall_pend_r <= in_ch.edge_falling;
    end else if (push) begin
      // drop the rising edge first, the falling one after it
      if (rise_pend_r) begin
        rise_pend_r <= 1'b0;
      end else begin
        fall_pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ts_r <= in_ch.timestamp;
    end
  end

endmodule

/* hdl/aht_fifo.sv */
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - token queue
// Short first-in first-out queue between the edge splitter and the engine.
// ----------------------------------------------------------------------------
module aht_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = aht_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (cnt_r == CNT_BITS'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = mem_r[rd_ptr_r];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    ptr_inc = (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* hdl/aht_back.sv */
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - threshold engine
// Holds config and adaptive state, registers each threshold result, recomputes
// the hysteresis offset: maximum on saturation, else a serial scaled divider.
// ----------------------------------------------------------------------------
module aht_back #(
  parameter int TIME_BITS = aht_pkg::TIME_BITS_DEF,
  parameter int DAC_BITS  = aht_pkg::DAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aht_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [aht_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                              tok_valid,
  input  aht_pkg::tok_ctl_t                 tok_ctl,
  input  logic [TIME_BITS-1:0]              tok_ts,
  output logic                              tok_pop,
  aht_out_if.source                         out_ch
);

  localparam int CNT_BITS = aht_pkg::CNT_BITS;
  localparam int PER_BITS = aht_pkg::PERIOD_BITS;
  localparam int SAT_BITS = aht_pkg::SAT_BITS;
  localparam int NUM_BITS = CNT_BITS + SAT_BITS;
  localparam int CMP_BITS = (NUM_BITS > TIME_BITS) ? NUM_BITS : TIME_BITS;
  localparam int QB       = DAC_BITS + 1;
  localparam int BB       = $clog2(QB);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CMP,
    ST_DIV,
    ST_FIX,
    ST_EMIT
  } state_t;

  state_t               state_r;

  // configuration
  logic [DAC_BITS-1:0]  center_r;
  logic [DAC_BITS-1:0]  hmin_r;
  logic [DAC_BITS-1:0]  hmax_r;
  logic [PER_BITS-1:0]  period_r;
  logic [SAT_BITS-1:0]  sat_r;
  logic                 adapt_en_r;

  // adaptive state
  logic [CNT_BITS-1:0]  tooth_cnt_r;
  logic [TIME_BITS-1:0] prev_time_r;
  logic [DAC_BITS-1:0]  hyst_offset_r;

  // current token and arithmetic
  logic                 rise_r;
  logic                 last_r;
  logic [TIME_BITS-1:0] ts_r;
  logic [TIME_BITS-1:0] dt_r;
  logic [NUM_BITS-1:0]  num_r;
  logic [TIME_BITS-1:0] rem_r;
  logic [QB-1:0]        q_r;
  logic [QB-1:0]        m_r;
  logic [BB-1:0]        bit_r;
  logic                 ph_r;
  logic                 up_r;

  // result register
  logic                 out_valid_r;
  logic [DAC_BITS-1:0]  out_thr_r;
  logic                 out_rise_r;
  logic                 out_last_r;

  logic [CNT_BITS-1:0]  cnt_inc;
  logic [TIME_BITS-1:0] num_t;
  logic                 dbl_ge;
  logic                 add_ge;
  logic [QB:0]          q_inc;
  logic [QB-1:0]        half_up;
  logic [QB-1:0]        t_dn;
  logic [DAC_BITS-1:0]  off_fix;
  logic [DAC_BITS:0]    sum_hi;
  logic [DAC_BITS-1:0]  thr;
  logic                 slot_free;

  assign tok_pop   = (state_r == ST_IDLE) && tok_valid;
  assign cnt_inc   = (tooth_cnt_r == '1) ? tooth_cnt_r : tooth_cnt_r + 1'b1;
  assign num_t     = TIME_BITS'(num_r);
  assign dbl_ge    = rem_r >= (dt_r - rem_r);
  assign add_ge    = rem_r >= (dt_r - num_t);

  // round half up going upward; going downward round the magnitude so that
  // an exact half still moves the offset up
  assign q_inc     = {1'b0, q_r} + 1'b1;
  assign half_up   = q_inc[QB:1];
  assign t_dn      = q_r[0] ? (q_r >> 1) + QB'(rem_r != '0) : (q_r >> 1);
  assign off_fix   = up_r ? DAC_BITS'({1'b0, hmin_r} + half_up)
                          : DAC_BITS'({1'b0, hmin_r} - t_dn);

  assign sum_hi    = {1'b0, center_r} + {1'b0, hyst_offset_r};
  assign thr       = rise_r ? ((center_r >= hyst_offset_r) ? center_r - hyst_offset_r : '0)
                            : (sum_hi[DAC_BITS] ? '1 : sum_hi[DAC_BITS-1:0]);
  assign slot_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.dac_threshold = out_thr_r;
  assign out_ch.was_rising    = out_rise_r;
  assign out_ch.last          = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      center_r      <= DAC_BITS'(aht_pkg::CENTER_RESET);
      hmin_r        <= DAC_BITS'(aht_pkg::HYST_MIN_RESET);
      hmax_r        <= DAC_BITS'(aht_pkg::HYST_MAX_RESET);
      period_r      <= PER_BITS'(aht_pkg::PERIOD_RESET);
      sat_r         <= '0;
      adapt_en_r    <= 1'b1;
      tooth_cnt_r   <= '0;
      prev_time_r   <= '0;
      hyst_offset_r <= DAC_BITS'(aht_pkg::HYST_MIN_RESET);
      out_valid_r   <= 1'b0;
    end else begin
      // load a new beat or drop the one just taken
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (tok_valid) begin
            if (!adapt_en_r) begin
              state_r <= ST_EMIT;
            end else begin
              tooth_cnt_r <= cnt_inc;
              if (tooth_cnt_r <= CNT_BITS'(period_r)) begin
                state_r <= ST_EMIT;
              end else begin
                state_r <= ST_MUL;
              end
            end
          end
        end
        ST_MUL: begin
          state_r <= ST_CMP;
        end
        ST_CMP: begin
          if (sat_r == '0 || CMP_BITS'(num_r) >= CMP_BITS'(dt_r)) begin
            hyst_offset_r <= hmax_r;
            tooth_cnt_r   <= '0;
            prev_time_r   <= ts_r;
            state_r       <= ST_EMIT;
          end else begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (ph_r && bit_r == '0) begin
            state_r <= ST_FIX;
          end
        end
        ST_FIX: begin
          hyst_offset_r <= off_fix;
          tooth_cnt_r   <= '0;
          prev_time_r   <= ts_r;
          state_r       <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase

      if (cfg_we) begin
        case (cfg_idx)
          aht_pkg::REG_CENTER_DAC: center_r <= cfg_wdata[DAC_BITS-1:0];
          aht_pkg::REG_HYST_MIN: begin
            hmin_r        <= cfg_wdata[DAC_BITS-1:0];
            hyst_offset_r <= cfg_wdata[DAC_BITS-1:0];
          end
          aht_pkg::REG_HYST_MAX:   hmax_r     <= cfg_wdata[DAC_BITS-1:0];
          aht_pkg::REG_PERIOD:     period_r   <= cfg_wdata[PER_BITS-1:0];
          aht_pkg::REG_SAT_TICKS:  sat_r      <= cfg_wdata[SAT_BITS-1:0];
          aht_pkg::REG_ADAPT_EN:   adapt_en_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (tok_valid) begin
          rise_r <= tok_ctl.rising;
          last_r <= tok_ctl.last;
          ts_r   <= tok_ts;
          dt_r   <= tok_ts - prev_time_r;
        end
      end
      ST_MUL: begin
        num_r <= tooth_cnt_r * sat_r;
      end
      ST_CMP: begin
        up_r  <= hmax_r >= hmin_r;
        m_r   <= (hmax_r >= hmin_r) ? {hmax_r - hmin_r, 1'b0} : {hmin_r - hmax_r, 1'b0};
        rem_r <= '0;
        q_r   <= '0;
        bit_r <= BB'(QB - 1);
        ph_r  <= 1'b0;
      end
      ST_DIV: begin
        if (!ph_r) begin
          // double the remainder, one quotient bit
          q_r   <= {q_r[QB-2:0], dbl_ge};
          rem_r <= dbl_ge ? rem_r - (dt_r - rem_r) : rem_r + rem_r;
          ph_r  <= 1'b1;
        end else begin
          // add the numerator where the multiplier bit is set
          if (m_r[bit_r]) begin
            if (add_ge) begin
              q_r   <= q_r + 1'b1;
              rem_r <= rem_r - (dt_r - num_t);
            end else begin
              rem_r <= rem_r + num_t;
            end
          end
          ph_r <= 1'b0;
          if (bit_r != '0) begin
            bit_r <= bit_r - 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_thr_r  <= thr;
          out_rise_r <= rise_r;
          out_last_r <= last_r;
        end
      end
      default: ;
    endcase
  end

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < dt_r) && (num_t < dt_r))
    else $error("divider remainder or numerator not below elapsed time");

  a_fix_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIX && !cfg_we) |=> (tooth_cnt_r == '0) && (state_r == ST_EMIT))
    else $error("offset update did not clear tooth count");

  a_disabled_skips: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && tok_valid && !adapt_en_r) |=> (state_r == ST_EMIT))
    else $error("adaptation ran while disabled");

  a_sat_loads_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP && sat_r == '0 && !cfg_we) |=> (hyst_offset_r == $past(hmax_r)))
    else $error("zero saturation ticks did not select maximum offset");

endmodule

/* hdl/adaptive_hysteresis_threshold_core.sv */
// Path: an edge passes the splitter's pending flags, the token queue, the
//   engine's token registers and the result register; an update adds the
//   multiply and compare states and, if interpolated, the serial divider.
// Flow: the engine takes no new edge until its result is loaded; an event
//   with both edges flagged gives two results.
// Reset: synchronous, active low; configuration, count, time and offset go
//   to their reset values at once, no clearing pass.
// ----------------------------------------------------------------------------
// Adaptive hysteresis threshold - top level
// Edge splitter and threshold engine joined by a short token queue.
// ----------------------------------------------------------------------------
module adaptive_hysteresis_threshold_core #(
  parameter int TIME_BITS = aht_pkg::TIME_BITS_DEF,
  parameter int DAC_BITS  = aht_pkg::DAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [aht_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [aht_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  aht_in_if.sink                            in_ch,
  aht_out_if.source                         out_ch
);

  localparam int TOK_BITS = $bits(aht_pkg::tok_ctl_t) + TIME_BITS;

  logic                 push;
  logic                 q_full;
  aht_pkg::tok_ctl_t    push_ctl;
  logic [TIME_BITS-1:0] push_ts;
  logic                 tok_valid;
  logic                 tok_pop;
  logic [TOK_BITS-1:0]  tok_data;
  aht_pkg::tok_ctl_t    tok_ctl;
  logic [TIME_BITS-1:0] tok_ts;

  assign tok_ctl = tok_data[TOK_BITS-1:TIME_BITS];
  assign tok_ts  = tok_data[TIME_BITS-1:0];

  aht_front #(
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_ctl (push_ctl),
    .push_ts  (push_ts)
  );

  aht_fifo #(
    .WIDTH (TOK_BITS),
    .DEPTH (aht_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_ctl, push_ts}),
    .full      (q_full),
    .pop       (tok_pop),
    .valid     (tok_valid),
    .pop_data  (tok_data)
  );

  aht_back #(
    .TIME_BITS (TIME_BITS),
    .DAC_BITS  (DAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .tok_valid (tok_valid),
    .tok_ctl   (tok_ctl),
    .tok_ts    (tok_ts),
    .tok_pop   (tok_pop),
    .out_ch    (out_ch)
  );

endmodule
